// File: rtl/gccd_pkg.sv
// ============================================================================
// gccd_pkg
// Shared constants, tables and types for the great-circle course and
// distance pipeline.
// ============================================================================
package gccd_pkg;

    // Angle fixed point: degrees with this many fraction bits
    localparam int ANGLE_FRAC_BITS = 16;

    // Field widths
    localparam int LAT_W   = 24;
    localparam int LON_W   = 25;
    localparam int DEG_W   = 25;
    localparam int CT_W    = 25;
    localparam int DIST_W  = 19;
    localparam int VAR_W   = 9;
    localparam int RAD_W   = 23;

    // Binary angle: 2^32 per turn
    localparam int BAM_W   = 32;

    // CORDIC
    localparam int CORDIC_ITERS = 30;
    localparam int ROT_W        = 34;
    localparam int VEC_W        = 36;
    localparam int TRIG_W       = 32;
    localparam logic [TRIG_W-1:0] CORDIC_GAIN = 32'd652032874;

    localparam logic [BAM_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // Degrees to binary angle: q = floor((|v|*2^(32-F) + 180) / 360)
    //   = qa * 2^(29-F) + tab[ra], with |v| = 45*qa + ra
    localparam int BAM_SHIFT      = 29 - ANGLE_FRAC_BITS;
    localparam int BAM_DIV        = 45;
    localparam int BAM_RECIP_SH   = 31;
    localparam int BAM_RECIP_W    = 26;
    localparam logic [BAM_RECIP_W-1:0] BAM_RECIP =
        BAM_RECIP_W'(((64'd1 << BAM_RECIP_SH) + BAM_DIV - 1) / BAM_DIV);
    localparam int BAM_QA_W       = 20;
    localparam int BAM_RA_W       = 6;

    typedef logic [BAM_SHIFT-1:0] bam_tab_t [BAM_DIV];

    function automatic bam_tab_t build_bam_tab();
        bam_tab_t t;
        for (int i = 0; i < BAM_DIV; i++) begin
            t[i] = BAM_SHIFT'((longint'(i) * (64'd1 << (32 - ANGLE_FRAC_BITS)) + 180) / 360);
        end
        return t;
    endfunction

    localparam bam_tab_t BAM_TAB = build_bam_tab();

    // Integer square root datapath width
    localparam int SQ_W   = 62;
    localparam int SQ_IN_W = 61;
    localparam int SQ_OUT_W = 31;
    localparam int SQ_STEPS = 31;

    // Distance scaling
    localparam logic [20:0] DIST_SCALE = 21'd1686630;
    localparam logic [CT_W-1:0] TURN_FIXED = CT_W'(360 << ANGLE_FRAC_BITS);

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_MAG_VAR      = 1'b0,
        REG_EARTH_RADIUS = 1'b1
    } cfg_reg_t;

endpackage

// File: rtl/gccd_bam.sv
// ============================================================================
// gccd_bam
// Fixed-point degrees to 32-bit binary angle, rounded half away from zero.
// Four register stages.
// ============================================================================
module gccd_bam #(
    parameter int TAG_W = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic signed [gccd_pkg::DEG_W-1:0]   deg,
    input  logic        [TAG_W-1:0]             tag_in,
    output logic        [gccd_pkg::BAM_W-1:0]   bam,
    output logic        [TAG_W-1:0]             tag_out
);
    import gccd_pkg::*;

    localparam int PROD_W = DEG_W + BAM_RECIP_W;

    logic [DEG_W-1:0]    ax1_reg, ax2_reg;
    logic                neg1_reg, neg2_reg, neg3_reg;
    logic [PROD_W-1:0]   prod2_reg;
    logic [BAM_QA_W-1:0] qa3_reg;
    logic [BAM_RA_W-1:0] ra3_reg;
    logic [BAM_W-1:0]    bam4_reg;
    logic [TAG_W-1:0]    tag_reg [4];

    logic [DEG_W-1:0]    rem_next;
    logic [BAM_W-1:0]    mag_next;

    // remainder after dividing by 45
    assign rem_next = ax2_reg - DEG_W'(prod2_reg[PROD_W-1:BAM_RECIP_SH] * BAM_DIV);
    assign mag_next = (BAM_W'(qa3_reg) << BAM_SHIFT) + BAM_W'(BAM_TAB[ra3_reg]);

    // datapath
    always_ff @(posedge clk) begin
        if (en)
        begin
            neg1_reg  <= deg[DEG_W-1];
            ax1_reg   <= deg[DEG_W-1] ? DEG_W'(-deg) : DEG_W'(deg);
            neg2_reg  <= neg1_reg;
            ax2_reg   <= ax1_reg;
            prod2_reg <= PROD_W'(ax1_reg) * PROD_W'(BAM_RECIP);
            neg3_reg  <= neg2_reg;
            qa3_reg   <= BAM_QA_W'(prod2_reg[PROD_W-1:BAM_RECIP_SH]);
            ra3_reg   <= rem_next[BAM_RA_W-1:0];
            bam4_reg  <= neg3_reg ? -mag_next : mag_next;
        end
    end

    // tag pipeline
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++) tag_reg[i] <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
            for (int i = 1; i < 4; i++) tag_reg[i] <= tag_reg[i-1];
        end
    end

    assign bam     = bam4_reg;
    assign tag_out = tag_reg[3];

endmodule

// File: rtl/gccd_rot.sv
// ============================================================================
// gccd_rot
// Rotation CORDIC: cosine and sine of a binary angle in Q30, one iteration
// per stage.
// ============================================================================
module gccd_rot #(
    parameter int TAG_W = 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic        [gccd_pkg::BAM_W-1:0]    angle,
    input  logic        [TAG_W-1:0]              tag_in,
    output logic signed [gccd_pkg::TRIG_W-1:0]   cos_out,
    output logic signed [gccd_pkg::TRIG_W-1:0]   sin_out,
    output logic        [TAG_W-1:0]              tag_out
);
    import gccd_pkg::*;

    logic signed [ROT_W-1:0]  x_reg [CORDIC_ITERS+1];
    logic signed [ROT_W-1:0]  y_reg [CORDIC_ITERS+1];
    logic signed [ROT_W-1:0]  z_reg [CORDIC_ITERS+1];
    logic                     neg_reg [CORDIC_ITERS+1];
    logic        [TAG_W-1:0]  tag_reg [CORDIC_ITERS+2];
    logic signed [TRIG_W-1:0] cos_reg, sin_reg;

    logic             fold;
    logic [BAM_W-1:0] folded;

    // second and third quadrant: rotate by a half turn, negate at the end
    assign fold   = angle[BAM_W-1] ^ angle[BAM_W-2];
    assign folded = {angle[BAM_W-1] ^ fold, angle[BAM_W-2:0]};

    // entry stage
    always_ff @(posedge clk) begin
        if (en)
        begin
            x_reg[0]   <= ROT_W'(CORDIC_GAIN);
            y_reg[0]   <= '0;
            z_reg[0]   <= {{(ROT_W-BAM_W){folded[BAM_W-1]}}, folded};
            neg_reg[0] <= fold;
        end
    end

    // iterations
    for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
        always_ff @(posedge clk) begin
            if (en)
            begin
                neg_reg[i+1] <= neg_reg[i];
                if (!z_reg[i][ROT_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - $signed({{(ROT_W-BAM_W){1'b0}}, ATAN_TAB[i]});
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + $signed({{(ROT_W-BAM_W){1'b0}}, ATAN_TAB[i]});
                end
            end
        end
    end

    // sign restore
    always_ff @(posedge clk) begin
        if (en)
        begin
            cos_reg <= TRIG_W'(neg_reg[CORDIC_ITERS] ? -x_reg[CORDIC_ITERS]
                                                     : x_reg[CORDIC_ITERS]);
            sin_reg <= TRIG_W'(neg_reg[CORDIC_ITERS] ? -y_reg[CORDIC_ITERS]
                                                     : y_reg[CORDIC_ITERS]);
        end
    end

    // tag pipeline
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            for (int i = 0; i < CORDIC_ITERS + 2; i++) tag_reg[i] <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
            for (int i = 1; i < CORDIC_ITERS + 2; i++) tag_reg[i] <= tag_reg[i-1];
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;
    assign tag_out = tag_reg[CORDIC_ITERS+1];

endmodule

// File: rtl/gccd_vec.sv
// ============================================================================
// gccd_vec
// Vectoring CORDIC: atan2(y, x) as a 32-bit binary angle, one iteration per
// stage. A zero vector gives 0.
// ============================================================================
module gccd_vec #(
    parameter int TAG_W = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic signed [gccd_pkg::VEC_W-1:0]   x_in,
    input  logic signed [gccd_pkg::VEC_W-1:0]   y_in,
    input  logic        [TAG_W-1:0]             tag_in,
    output logic        [gccd_pkg::BAM_W-1:0]   angle,
    output logic        [TAG_W-1:0]             tag_out
);
    import gccd_pkg::*;

    logic signed [VEC_W-1:0] x_reg [CORDIC_ITERS+1];
    logic signed [VEC_W-1:0] y_reg [CORDIC_ITERS+1];
    logic        [BAM_W-1:0] z_reg [CORDIC_ITERS+1];
    logic                    zero_reg [CORDIC_ITERS+1];
    logic        [TAG_W-1:0] tag_reg [CORDIC_ITERS+1];

    // entry: fold the left half plane
    always_ff @(posedge clk) begin
        if (en)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in[VEC_W-1])
            begin
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
                z_reg[0] <= {1'b1, {(BAM_W-1){1'b0}}};
            end
            else
            begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
        end
    end

    // iterations
    for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
        always_ff @(posedge clk) begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (!y_reg[i][VEC_W-1] && (y_reg[i] != '0))
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_TAB[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_TAB[i];
                end
            end
        end
    end

    // tag pipeline
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            for (int i = 0; i < CORDIC_ITERS + 1; i++) tag_reg[i] <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
            for (int i = 1; i < CORDIC_ITERS + 1; i++) tag_reg[i] <= tag_reg[i-1];
        end
    end

    assign angle   = zero_reg[CORDIC_ITERS] ? '0 : z_reg[CORDIC_ITERS];
    assign tag_out = tag_reg[CORDIC_ITERS];

endmodule

// File: rtl/gccd_isqrt.sv
// ============================================================================
// gccd_isqrt
// Pipelined integer square root, one result bit per stage.
// ============================================================================
module gccd_isqrt #(
    parameter int TAG_W = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic [gccd_pkg::SQ_IN_W-1:0]        radicand,
    input  logic [TAG_W-1:0]                    tag_in,
    output logic [gccd_pkg::SQ_OUT_W-1:0]       root,
    output logic [TAG_W-1:0]                    tag_out
);
    import gccd_pkg::*;

    logic [SQ_W-1:0]  rem_reg  [SQ_STEPS+1];
    logic [SQ_W-1:0]  r_reg    [SQ_STEPS+1];
    logic [TAG_W-1:0] tag_reg  [SQ_STEPS+1];

    // entry
    always_ff @(posedge clk) begin
        if (en)
        begin
            rem_reg[0] <= SQ_W'(radicand);
            r_reg[0]   <= '0;
        end
    end

    // one bit per stage, trial bit 4^(30-i)
    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
        localparam logic [SQ_W-1:0] TRIAL = SQ_W'(1) << (2 * (SQ_STEPS - 1 - i));
        logic [SQ_W-1:0] sum;
        assign sum = r_reg[i] + TRIAL;
        always_ff @(posedge clk) begin
            if (en)
            begin
                if (rem_reg[i] >= sum)
                begin
                    rem_reg[i+1] <= rem_reg[i] - sum;
                    r_reg[i+1]   <= (r_reg[i] >> 1) + TRIAL;
                end
                else
                begin
                    rem_reg[i+1] <= rem_reg[i];
                    r_reg[i+1]   <= r_reg[i] >> 1;
                end
            end
        end
    end

    // tag pipeline
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            for (int i = 0; i < SQ_STEPS + 1; i++) tag_reg[i] <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
            for (int i = 1; i < SQ_STEPS + 1; i++) tag_reg[i] <= tag_reg[i-1];
        end
    end

    assign root    = r_reg[SQ_STEPS][SQ_OUT_W-1:0];
    assign tag_out = tag_reg[SQ_STEPS];

endmodule

// File: rtl/great_circle_course_distance.sv
// ============================================================================
// great_circle_course_distance
// Initial great-circle course (true and magnetic) and spherical law of
// cosines distance between two points, fully pipelined.
// ============================================================================
//
//  channel   dir   fields (low bit first)
//  --------  ----  ------------------------------------------------------
//  s_*       in    origin_lat, origin_lon, dest_lat, dest_lon
//  m_*       out   course_true, course_magnetic, distance_sixteenths_km
//  cfg_*     in    0: magnetic_variation, 1: earth_radius_m
//
//  One request per clock while m_* is not stalled. From input accept to the output
//  register a request passes the two 30-step CORDIC chains and the 31-step root.
//  Reset clears valid bits and loads the register defaults.
//  A stall on m_* freezes the whole pipeline; s_tready follows it.
//
module great_circle_course_distance (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_lat[23:0], origin_lon[48:24], dest_lat[72:49], dest_lon[97:73], zero pad
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // course_true[24:0], course_magnetic[49:25], distance_sixteenths_km[68:50], zero pad
    output logic [71:0]  m_tdata,
    input  logic         cfg_wr_en,
    input  logic         cfg_addr,
    input  logic [22:0]  cfg_wdata
);
    import gccd_pkg::*;

    localparam int DX_W  = TRIG_W + 1;
    localparam int CC2_W = 2 * TRIG_W;
    localparam int ISQ_TAG_W = 2 + 2 * DX_W + TRIG_W;
    localparam int P1_W  = BAM_W + RAD_W;
    localparam int P2_W  = P1_W - 16 + 21;
    localparam int CTM_W = BAM_W + 9;
    localparam int MAG_W = CT_W + 2;

    localparam logic signed [TRIG_W-1:0] ONE_Q30 = TRIG_W'(1) << 30;

    function automatic logic signed [TRIG_W-1:0] qmul(
        input logic signed [TRIG_W-1:0] a,
        input logic signed [TRIG_W-1:0] b
    );
        logic signed [2*TRIG_W-1:0] p;
        p = (2*TRIG_W)'(a) * (2*TRIG_W)'(b);
        return p[TRIG_W+29:30];
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    logic signed [VAR_W-1:0] var_reg;
    logic        [RAD_W-1:0] radius_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            var_reg    <= VAR_W'(14);
            radius_reg <= RAD_W'(6377707);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_MAG_VAR:      var_reg    <= cfg_wdata[VAR_W-1:0];
                REG_EARTH_RADIUS: radius_reg <= cfg_wdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // global advance: the pipeline moves when the output slot is free
    logic en;
    logic m_valid_reg;
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // degrees to binary angle
    logic signed [DEG_W-1:0] lat1_deg, lon1_deg, lat2_deg, lon2_deg;
    logic [BAM_W-1:0] lat1_b, lon1_b, lat2_b, lon2_b;
    logic             v_b;

    assign lat1_deg = DEG_W'($signed(s_tdata[23:0]));
    assign lon1_deg = $signed(s_tdata[48:24]);
    assign lat2_deg = DEG_W'($signed(s_tdata[72:49]));
    assign lon2_deg = $signed(s_tdata[97:73]);

    gccd_bam #(.TAG_W(1)) u_bam_lat1 (
        .clk(clk), .rst_n(rst_n), .en(en), .deg(lat1_deg),
        .tag_in(s_tvalid), .bam(lat1_b), .tag_out(v_b));
    gccd_bam #(.TAG_W(1)) u_bam_lon1 (
        .clk(clk), .rst_n(rst_n), .en(en), .deg(lon1_deg),
        .tag_in(1'b0), .bam(lon1_b), .tag_out());
    gccd_bam #(.TAG_W(1)) u_bam_lat2 (
        .clk(clk), .rst_n(rst_n), .en(en), .deg(lat2_deg),
        .tag_in(1'b0), .bam(lat2_b), .tag_out());
    gccd_bam #(.TAG_W(1)) u_bam_lon2 (
        .clk(clk), .rst_n(rst_n), .en(en), .deg(lon2_deg),
        .tag_in(1'b0), .bam(lon2_b), .tag_out());

    // ------------------------------------------------------------------
    // longitude difference and coincident-point detect
    logic [BAM_W-1:0] lat1_d_reg, lat2_d_reg, dlon_d_reg;
    logic             coinc_d_reg, v_d_reg;

    always_ff @(posedge clk) begin
        if (en)
        begin
            lat1_d_reg  <= lat1_b;
            lat2_d_reg  <= lat2_b;
            dlon_d_reg  <= lon2_b - lon1_b;
            coinc_d_reg <= (lat1_b == lat2_b) && (lon1_b == lon2_b);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            v_d_reg <= 1'b0;
        else if (en)
            v_d_reg <= v_b;
    end

    // ------------------------------------------------------------------
    // sines and cosines
    logic signed [TRIG_W-1:0] c1, s1, c2, s2, cd, sd;
    logic [1:0]               rot_tag;

    gccd_rot #(.TAG_W(2)) u_rot_lat1 (
        .clk(clk), .rst_n(rst_n), .en(en), .angle(lat1_d_reg),
        .tag_in({v_d_reg, coinc_d_reg}), .cos_out(c1), .sin_out(s1),
        .tag_out(rot_tag));
    gccd_rot #(.TAG_W(1)) u_rot_lat2 (
        .clk(clk), .rst_n(rst_n), .en(en), .angle(lat2_d_reg),
        .tag_in(1'b0), .cos_out(c2), .sin_out(s2), .tag_out());
    gccd_rot #(.TAG_W(1)) u_rot_dlon (
        .clk(clk), .rst_n(rst_n), .en(en), .angle(dlon_d_reg),
        .tag_in(1'b0), .cos_out(cd), .sin_out(sd), .tag_out());

    // ------------------------------------------------------------------
    // product stage 1
    logic signed [TRIG_W-1:0] dy_p1_reg, t1_p1_reg, t2_p1_reg, u_p1_reg;
    logic signed [TRIG_W-1:0] w_p1_reg, cd_p1_reg;
    logic [1:0]               tag_p1_reg;

    always_ff @(posedge clk) begin
        if (en)
        begin
            dy_p1_reg <= qmul(sd, c2);
            t1_p1_reg <= qmul(c1, s2);
            t2_p1_reg <= qmul(s1, c2);
            u_p1_reg  <= qmul(c1, c2);
            w_p1_reg  <= qmul(s1, s2);
            cd_p1_reg <= cd;
        end
    end

    // product stage 2
    logic signed [TRIG_W-1:0] dy_p2_reg, t1_p2_reg, w_p2_reg, t2c_p2_reg, uc_p2_reg;
    logic [1:0]               tag_p2_reg;

    always_ff @(posedge clk) begin
        if (en)
        begin
            dy_p2_reg  <= dy_p1_reg;
            t1_p2_reg  <= t1_p1_reg;
            w_p2_reg   <= w_p1_reg;
            t2c_p2_reg <= qmul(t2_p1_reg, cd_p1_reg);
            uc_p2_reg  <= qmul(u_p1_reg, cd_p1_reg);
        end
    end

    // stage 3: course terms and clamped cosine of the central angle
    logic signed [DX_W-1:0]   cc_sum;
    logic signed [DX_W-1:0]   dx_p3_reg, dy_p3_reg;
    logic signed [TRIG_W-1:0] cc_p3_reg;
    logic [1:0]               tag_p3_reg;

    assign cc_sum = DX_W'(uc_p2_reg) + DX_W'(w_p2_reg);

    always_ff @(posedge clk) begin
        if (en)
        begin
            dx_p3_reg <= DX_W'(t1_p2_reg) - DX_W'(t2c_p2_reg);
            dy_p3_reg <= DX_W'(dy_p2_reg);
            if (cc_sum > DX_W'(ONE_Q30))
                cc_p3_reg <= ONE_Q30;
            else if (cc_sum < -DX_W'(ONE_Q30))
                cc_p3_reg <= -ONE_Q30;
            else
                cc_p3_reg <= TRIG_W'(cc_sum);
        end
    end

    // stage 4: square of the cosine
    logic [CC2_W-1:0]         cc2_q_reg;
    logic signed [DX_W-1:0]   dx_q_reg, dy_q_reg;
    logic signed [TRIG_W-1:0] cc_q_reg;
    logic [1:0]               tag_q_reg;

    always_ff @(posedge clk) begin
        if (en)
        begin
            cc2_q_reg <= CC2_W'(CC2_W'(cc_p3_reg) * CC2_W'(cc_p3_reg));
            dx_q_reg  <= dx_p3_reg;
            dy_q_reg  <= dy_p3_reg;
            cc_q_reg  <= cc_p3_reg;
        end
    end

    // valid and coincident flags through the product stages
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            tag_p1_reg <= '0;
            tag_p2_reg <= '0;
            tag_p3_reg <= '0;
            tag_q_reg  <= '0;
        end
        else if (en)
        begin
            tag_p1_reg <= rot_tag;
            tag_p2_reg <= tag_p1_reg;
            tag_p3_reg <= tag_p2_reg;
            tag_q_reg  <= tag_p3_reg;
        end
    end

    // ------------------------------------------------------------------
    // sine of the central angle: sqrt(1 - c^2)
    logic [SQ_IN_W-1:0]   radicand;
    logic [SQ_OUT_W-1:0]  sin_theta;
    logic [ISQ_TAG_W-1:0] isq_tag;
    logic signed [DX_W-1:0]   dx_s, dy_s;
    logic signed [TRIG_W-1:0] cc_s;
    logic [1:0]               tag_s;

    assign radicand = (SQ_IN_W'(1) << 60) - cc2_q_reg[SQ_IN_W-1:0];

    gccd_isqrt #(.TAG_W(ISQ_TAG_W)) u_isqrt (
        .clk(clk), .rst_n(rst_n), .en(en), .radicand(radicand),
        .tag_in({tag_q_reg, dx_q_reg, dy_q_reg, cc_q_reg}),
        .root(sin_theta), .tag_out(isq_tag));

    assign {tag_s, dx_s, dy_s, cc_s} = isq_tag;

    // ------------------------------------------------------------------
    // arctangents: course and central angle
    logic [BAM_W-1:0] zc, zt;
    logic [1:0]       tag_v;

    gccd_vec #(.TAG_W(2)) u_vec_course (
        .clk(clk), .rst_n(rst_n), .en(en),
        .x_in(VEC_W'(dx_s)), .y_in(VEC_W'(dy_s)),
        .tag_in(tag_s), .angle(zc), .tag_out(tag_v));

    gccd_vec #(.TAG_W(1)) u_vec_dist (
        .clk(clk), .rst_n(rst_n), .en(en),
        .x_in(VEC_W'(cc_s)), .y_in(VEC_W'(sin_theta)),
        .tag_in(1'b0), .angle(zt), .tag_out());

    // ------------------------------------------------------------------
    // finish stage 1: course to degrees, angle times radius
    logic [CTM_W-1:0]  ctm;
    logic [BAM_W-1:0]  theta;
    logic [CT_W-1:0]   ct_f1_reg;
    logic [P1_W-1:0]   p1_f1_reg;
    logic [1:0]        tag_f1_reg;

    assign ctm = CTM_W'(CTM_W'(zc) * CTM_W'(360))
               + (CTM_W'(1) << (31 - ANGLE_FRAC_BITS));

    always_comb begin
        if (zt > {1'b1, {(BAM_W-1){1'b0}}})
            theta = (zt < {2'b11, {(BAM_W-2){1'b0}}}) ? {1'b1, {(BAM_W-1){1'b0}}} : '0;
        else
            theta = zt;
    end

    always_ff @(posedge clk) begin
        if (en)
        begin
            ct_f1_reg <= CT_W'(ctm >> (32 - ANGLE_FRAC_BITS));
            p1_f1_reg <= P1_W'(theta) * P1_W'(radius_reg);
        end
    end

    // finish stage 2: wrap course, scale distance
    logic [CT_W-1:0] ct_f2_reg;
    logic [P2_W-1:0] p2_f2_reg;
    logic [1:0]      tag_f2_reg;

    always_ff @(posedge clk) begin
        if (en)
        begin
            ct_f2_reg <= (tag_f1_reg[0] || (ct_f1_reg >= TURN_FIXED)) ? '0 : ct_f1_reg;
            p2_f2_reg <= P2_W'(p1_f1_reg[P1_W-1:16]) * P2_W'(DIST_SCALE);
        end
    end

    // output register: magnetic course and rounded, saturated distance
    logic signed [MAG_W-1:0] mag_sum, mag_wrap;
    logic [P2_W:0]           dist_round;
    logic [P2_W-40:0]        dist_full;
    logic [DIST_W-1:0]       dist_sat;
    logic [CT_W-1:0]         ct_o_reg, mag_o_reg;
    logic [DIST_W-1:0]       dist_o_reg;

    assign mag_sum = $signed({2'b00, ct_f2_reg})
                   + $signed({{(MAG_W-VAR_W-ANGLE_FRAC_BITS){var_reg[VAR_W-1]}},
                              var_reg, {ANGLE_FRAC_BITS{1'b0}}});

    always_comb begin
        if (mag_sum < 0)
            mag_wrap = mag_sum + $signed({2'b00, TURN_FIXED});
        else if (mag_sum >= $signed({2'b00, TURN_FIXED}))
            mag_wrap = mag_sum - $signed({2'b00, TURN_FIXED});
        else
            mag_wrap = mag_sum;
    end

    assign dist_round = (P2_W+1)'(p2_f2_reg) + ((P2_W+1)'(1) << 39);
    assign dist_full  = dist_round[P2_W:40];
    assign dist_sat   = (dist_full > (P2_W-39)'({DIST_W{1'b1}})) ? {DIST_W{1'b1}}
                                                                 : DIST_W'(dist_full);

    always_ff @(posedge clk) begin
        if (en)
        begin
            ct_o_reg   <= ct_f2_reg;
            mag_o_reg  <= CT_W'(mag_wrap);
            dist_o_reg <= tag_f2_reg[0] ? '0 : dist_sat;
        end
    end

    // valid flags through the finish stages
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            tag_f1_reg  <= '0;
            tag_f2_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            tag_f1_reg  <= tag_v;
            tag_f2_reg  <= tag_f1_reg;
            m_valid_reg <= tag_f2_reg[1];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, dist_o_reg, mag_o_reg, ct_o_reg};

endmodule

// File: dv/tb_great_circle_course_distance.sv
// ----------------------------------------------------------------------------
// tb_great_circle_course_distance
// Self-checking bench for the great-circle course and distance pipeline.
// A bit-exact fixed-point predictor computes the true course, the magnetic
// course and the distance for every accepted request. Each returned result
// is compared with the oldest expected one. The bench steps through several
// register settings, adds random idle and stall bursts on both sides, and
// holds the output off once for a long stretch to back up the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_great_circle_course_distance;
    import gccd_pkg::*;

    localparam longint DEG      = 64'd1 << ANGLE_FRAC_BITS;
    localparam longint TURN     = 64'd360 << ANGLE_FRAC_BITS;
    localparam longint ONE      = 64'd1 << 30;
    localparam int     LATENCY  = 107;
    localparam int     WD_LIMIT = 20000;
    localparam int     HOLD_LEN = 400;

    typedef struct packed {
        logic [DIST_W-1:0] dist_km;
        logic [CT_W-1:0]   mag;
        logic [CT_W-1:0]   ct;
    } course_t;

    // ------------------------------------------------------------------
    // Scoreboard: fixed-point course/distance predictor and result queue
    // ------------------------------------------------------------------
    class course_scoreboard;
        course_t             pending_q[$];
        logic signed [VAR_W-1:0] mag_var = 9'sd14;
        logic [RAD_W-1:0]    radius  = 23'd6377707;
        int                  errors  = 0;
        int                  results = 0;

        function automatic logic [31:0] deg_to_bam(longint v);
            longint p, q;
            p = v <<< 32;
            if (p >= 0) q = (p + TURN / 2) / TURN;
            else        q = -((-p + TURN / 2) / TURN);
            return q[31:0];
        endfunction

        // rotation CORDIC, gain pre-applied, Q30 out
        function automatic void sin_cos(logic [31:0] a, output longint c, output longint s);
            longint x, y, z, nx;
            bit     neg;
            x = CORDIC_GAIN;
            y = 0;
            neg = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
            if (neg) a = a - 32'h80000000;
            z = longint'(signed'(a));
            for (int i = 0; i < CORDIC_ITERS; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - longint'(ATAN_TAB[i]);
                end
                else begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + longint'(ATAN_TAB[i]);
                end
                x = nx;
            end
            c = neg ? -x : x;
            s = neg ? -y : y;
        endfunction

        // vectoring CORDIC, binary angle out
        function automatic logic [31:0] arctan2(longint y, longint x);
            logic [31:0] z;
            longint      nx;
            z = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = 32'h80000000;
            end
            for (int i = 0; i < CORDIC_ITERS; i++) begin
                if (y > 0) begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + ATAN_TAB[i];
                end
                else begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - ATAN_TAB[i];
                end
                x = nx;
            end
            return z;
        endfunction

        function automatic longint unsigned int_sqrt(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end
                else r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function automatic longint q30_mul(longint a, longint b);
            return (a * b) >>> 30;
        endfunction

        function automatic course_t predict(logic [103:0] d);
            logic [31:0]      lat1, lat2, lon1, lon2, dlon, zc, zt;
            longint           c1, s1, c2, s2, cd, sd, dx, dy, cc, mg;
            longint unsigned  ct, dist_v, theta, p;
            course_t          r;
            lat1 = deg_to_bam(longint'(signed'(d[23:0])));
            lon1 = deg_to_bam(longint'(signed'(d[48:24])));
            lat2 = deg_to_bam(longint'(signed'(d[72:49])));
            lon2 = deg_to_bam(longint'(signed'(d[97:73])));
            dlon = lon2 - lon1;
            ct = 0;
            dist_v = 0;
            sin_cos(lat1, c1, s1);
            sin_cos(lat2, c2, s2);
            sin_cos(dlon, cd, sd);
            // coincident points leave course and distance at zero
            if (!(lat1 == lat2 && dlon == 0)) begin
                dy = q30_mul(sd, c2);
                dx = q30_mul(c1, s2) - q30_mul(q30_mul(s1, c2), cd);
                zc = arctan2(dy, dx);
                ct = (longint'(zc) * 360 + (64'd1 << (31 - ANGLE_FRAC_BITS)))
                     >> (32 - ANGLE_FRAC_BITS);
                if (ct >= TURN) ct = 0;
                cc = q30_mul(q30_mul(c1, c2), cd) + q30_mul(s1, s2);
                if (cc > ONE)  cc = ONE;
                if (cc < -ONE) cc = -ONE;
                zt = arctan2(longint'(int_sqrt(ONE * ONE - cc * cc)), cc);
                // residue past the half turn folds to 0 or 180 degrees
                if (zt > 32'h80000000) theta = (zt < 32'hC0000000) ? 64'h80000000 : 0;
                else                   theta = zt;
                p = (theta * radius) >> 16;
                dist_v = (p * DIST_SCALE + (64'd1 << 39)) >> 40;
                if (dist_v > 64'h7FFFF) dist_v = 64'h7FFFF;
            end
            mg = (longint'(ct) + longint'(mag_var) * DEG) % TURN;
            if (mg < 0) mg = mg + TURN;
            r.ct      = ct[CT_W-1:0];
            r.mag     = mg[CT_W-1:0];
            r.dist_km = dist_v[DIST_W-1:0];
            return r;
        endfunction

        function void note_request(logic [103:0] d);
            pending_q.push_back(predict(d));
        endfunction

        function void check_result(logic [71:0] t);
            course_t got, exp_r;
            got = t[68:0];
            results++;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, t);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (got.ct !== exp_r.ct) begin
                $display("%0t: course_true exp %0d got %0d", $realtime, exp_r.ct, got.ct);
                errors++;
            end
            if (got.mag !== exp_r.mag) begin
                $display("%0t: course_magnetic exp %0d got %0d", $realtime, exp_r.mag, got.mag);
                errors++;
            end
            if (got.dist_km !== exp_r.dist_km) begin
                $display("%0t: distance exp %0d got %0d", $realtime, exp_r.dist_km,
                         got.dist_km);
                errors++;
            end
            if (t[71:69] !== 3'b0) begin
                $display("%0t: pad bits exp 0 got %b", $realtime, t[71:69]);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------
    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;
    logic         cfg_wr_en = 1'b0;
    logic         cfg_addr = 1'b0;
    logic [22:0]  cfg_wdata = '0;

    course_scoreboard sb = new();
    bit  idle_en   = 1'b1;
    bit  hold_req  = 1'b0;
    int  n_sent    = 0;
    int  n_cfg     = 0;
    int  quiet_cyc = 0;

    great_circle_course_distance u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Watchdog on cycles without any handshake
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cyc <= 0;
        else quiet_cyc <= quiet_cyc + 1;
        if (quiet_cyc >= WD_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $realtime, sb.pending_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stall bursts, one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_LEN;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= 1'b1;
                if (idle_en && rst_n && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 8);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side tasks
    // ------------------------------------------------------------------
    function automatic logic [103:0] pack_req(longint la1, longint lo1, longint la2, longint lo2);
        logic [103:0] d;
        d = '0;
        d[23:0]  = la1[23:0];
        d[48:24] = lo1[24:0];
        d[72:49] = la2[23:0];
        d[97:73] = lo2[24:0];
        return d;
    endfunction

    task automatic send_req(logic [103:0] d);
        int gap;
        if (idle_en && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge clk); while (!s_tready);
        sb.note_request(d);
        n_sent++;
    endtask

    // wait for the pipeline to drain, then for its depth
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    task automatic write_cfg(cfg_reg_t idx, logic [22:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_MAG_VAR) sb.mag_var = val[VAR_W-1:0];
        else                    sb.radius  = val;
        n_cfg++;
    endtask

    task automatic set_cfg(int var_deg, int radius);
        drain();
        write_cfg(REG_MAG_VAR, 23'(var_deg));
        write_cfg(REG_EARTH_RADIUS, 23'(radius));
    endtask

    function automatic longint rnd_lat();
        return longint'($urandom_range(0, 11796480)) - 5898240;
    endfunction

    function automatic longint rnd_lon();
        return longint'($urandom_range(0, 23592960)) - 11796480;
    endfunction

    // mix of in-range pairs, near and equal points, antipodes and raw bits
    task automatic send_random(int n);
        longint la1, lo1, la2, lo2;
        int     sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            la1 = rnd_lat();
            lo1 = rnd_lon();
            la2 = rnd_lat();
            lo2 = rnd_lon();
            if (sel < 8) begin
                la2 = la1 + $urandom_range(0, 64) - 32;
                lo2 = lo1 + $urandom_range(0, 64) - 32;
            end
            else if (sel < 12) begin
                la2 = la1;
                lo2 = lo1 + 360 * DEG * ($urandom_range(0, 1) ? 1 : -1);
            end
            else if (sel < 16) begin
                la2 = -la1;
                lo2 = lo1 + 180 * DEG;
            end
            else if (sel < 20) begin
                la1 = ($urandom_range(0, 1) ? 90 : -90) * DEG;
            end
            if (sel >= 85)
                send_req({6'b0, 98'({$urandom(), $urandom(), $urandom(), $urandom()})});
            else
                send_req(pack_req(la1, lo1, la2, lo2));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: coincident, poles, antipodes, seam crossing, extremes
        send_req(pack_req(0, 0, 0, 0));
        send_req(pack_req(45 * DEG, 10 * DEG, 45 * DEG, 10 * DEG));
        send_req(pack_req(10 * DEG, 180 * DEG, 10 * DEG, -180 * DEG));
        send_req(pack_req(0, 0, 0, 90 * DEG));
        send_req(pack_req(0, 0, 0, -90 * DEG));
        send_req(pack_req(0, 0, 10 * DEG, 0));
        send_req(pack_req(10 * DEG, 0, 0, 0));
        send_req(pack_req(0, 0, 0, 180 * DEG));
        send_req(pack_req(30 * DEG, 20 * DEG, -30 * DEG, -160 * DEG));
        send_req(pack_req(90 * DEG, 0, -90 * DEG, 0));
        send_req(pack_req(90 * DEG, 0, 90 * DEG, 77 * DEG));
        send_req(pack_req(-90 * DEG, 180 * DEG, 45 * DEG, -180 * DEG));
        send_req(pack_req(0, 179 * DEG, 0, -179 * DEG));
        send_req(pack_req(5898240, 11796480, -5898240, -11796480));
        send_req(pack_req(-5898240, -11796480, 5898240, 11796480));
        send_req(pack_req(0, 0, 1, 0));
        send_req(pack_req(0, 0, 0, 1));
        send_req(pack_req(24'h7FFFFF, 25'h0FFFFFF, 24'h800000, 25'h1000000));
        send_req(pack_req(24'h800000, 25'h1000000, 24'h7FFFFF, 25'h0FFFFFF));
        send_req({6'b0, {98{1'b1}}});
        send_req(pack_req(45 * DEG, -75 * DEG, 51 * DEG, 0));
        send_random(150);

        // low extremes, with a long output hold-off to fill the pipe
        set_cfg(-180, 6300000);
        hold_req = 1'b1;
        send_random(250);

        set_cfg(180, 6400000);
        send_random(200);

        set_cfg(0, 23'h7FFFFF);
        send_random(100);

        set_cfg(-1, 6350000);
        send_random(150);

        set_cfg($urandom_range(0, 360) - 180, $urandom_range(6300000, 6400000));
        send_random(150);

        // closing stretch with no idling on either side
        set_cfg($urandom_range(0, 360) - 180, $urandom_range(6300000, 6400000));
        idle_en = 1'b0;
        send_random(250);

        drain();
        $display("Covered %0d requests and %0d results over %0d register writes,",
                 n_sent, sb.results, n_cfg);
        $display("with variation from -180 to 180 and radius sweeps incl. a full hold-off.");
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
